@@ hdl/gaze_fixation_smoother_assert.svh @@
// Assertion macros shared by the checker of the gaze fixation smoother.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef GAZE_FIXATION_SMOOTHER_ASSERT_SVH
`define GAZE_FIXATION_SMOOTHER_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define GFS_ASSERT_RUN(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Assertion that is also checked during reset.
`define GFS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hdl/gfs_pkg.sv @@
// Shared types and constants of the gaze fixation smoother.
// No dependencies; imported by every module of the block but gfs_ram.
`default_nettype none

package gfs_pkg;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] WEIGHT_RESET = 16'd58982;
  localparam logic [CFG_W-1:0] THRESH_RESET = 16'd800;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic {
    OP_REPEAT,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } qitem_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_DISP,
    ST_BLEND1,
    ST_BLEND2,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/gfs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/gfs_front.sv @@
// Front end: accepts gaze samples, classifies them and queues them.
// Depends on gfs_pkg.
`default_nettype none

module gfs_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [2*gfs_pkg::COORD_W-1:0] in_tdata,
  input  wire logic                        in_tuser,
  output logic                             q_valid,
  output gfs_pkg::qitem_t                  q_item,
  input  wire logic                        q_pop
);

  import gfs_pkg::*;

  qitem_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  qitem_t              new_item;

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = slot_r[rd_ptr_r];

  // An invalid sample only repeats the held result, so it is tagged apart.
  always_comb begin
    new_item.op = in_tuser ? OP_UPDATE : OP_REPEAT;
    new_item.x  = in_tdata[COORD_W-1:0];
    new_item.y  = in_tdata[2*COORD_W-1:COORD_W];
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/gfs_back.sv @@
// Back end: window ring, average, dispersion test, blend and result register.
// Depends on gfs_pkg and gfs_ram.
`default_nettype none

module gfs_back #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [gfs_pkg::CFG_W-1:0]    weight,
  input  wire logic [gfs_pkg::CFG_W-1:0]    threshold,
  input  wire logic                         q_valid,
  input  wire gfs_pkg::qitem_t              q_item,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [gfs_pkg::COORD_W-1:0]       out_smooth_x,
  output logic [gfs_pkg::COORD_W-1:0]       out_smooth_y,
  output logic                              out_fix
);

  import gfs_pkg::*;

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = COORD_W + AW;
  localparam int SQ_W  = 2 * COORD_W;
  // Floored reciprocal of the depth; the quotient it gives is low by at most one.
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW_DEPTH);

  state_t               state_r, state_nxt;
  qitem_t               item_r;
  logic [CW-1:0]        cnt_r;
  logic [AW-1:0]        slot_r;
  logic [WINDOW_DEPTH-1:0] vbits_r;
  logic                 rd_pend_r, rd_ok_r;
  logic [SQ_W-1:0]      rdata;
  logic [COORD_W-1:0]   rd_x, rd_y;
  logic [SQ_W-1:0]      lim_r;
  logic [SUM_W-1:0]     sum_x_r, sum_y_r;
  logic [COORD_W-1:0]   avg_x_r, avg_y_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r;
  logic                 sq_v_r;
  logic                 fix_r, was_fix_r;
  logic [COORD_W-1:0]   held_x_r, held_y_r;
  logic [SQ_W-1:0]      px_r, py_r;
  logic                 out_valid_r;
  logic [COORD_W-1:0]   out_x_r, out_y_r;
  logic                 out_fix_r;

  logic                 iss, load_out, out_free, cnt_done;
  logic [AW-1:0]        raddr;
  logic [2*SUM_W-1:0]   prod_x, prod_y;
  logic [SUM_W-1:0]     rem_x, rem_y;
  logic [COORD_W-1:0]   dx, dy;
  logic [COORD_W-1:0]   base_x, base_y;
  logic [COORD_W:0]     wcomp;
  logic [SQ_W:0]        acc_x, acc_y;
  logic [SQ_W:0]        dist_sq;

  assign raddr    = cnt_r[AW-1:0];
  assign cnt_done = (cnt_r == CW'(WINDOW_DEPTH));
  assign out_free = !out_valid_r || out_tready;

  gfs_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (state_r == ST_WRITE),
    .waddr (slot_r),
    .wdata ({item_r.y, item_r.x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries never written since reset read as zero.
  assign rd_x = rd_ok_r ? rdata[COORD_W-1:0] : '0;
  assign rd_y = rd_ok_r ? rdata[SQ_W-1:COORD_W] : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.op == OP_UPDATE) ? ST_WRITE : ST_OUT;
        end
      end
      ST_WRITE:   state_nxt = ST_SUM;
      ST_SUM: begin
        if (cnt_done && !rd_pend_r) begin
          state_nxt = ST_DIV_MUL;
        end
      end
      ST_DIV_MUL: state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: state_nxt = ST_DISP;
      ST_DISP: begin
        if (cnt_done && !rd_pend_r && !sq_v_r) begin
          state_nxt = ST_BLEND1;
        end
      end
      ST_BLEND1:  state_nxt = ST_BLEND2;
      ST_BLEND2:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    iss      = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:         q_pop    = q_valid;
      ST_SUM, ST_DISP: iss      = !cnt_done;
      ST_OUT:          load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        iss      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Average by reciprocal multiply, then a single correction step.
  assign prod_x = (2*SUM_W)'(sum_x_r) * (2*SUM_W)'(RECIP);
  assign prod_y = (2*SUM_W)'(sum_y_r) * (2*SUM_W)'(RECIP);
  assign rem_x  = sum_x_r - SUM_W'(SUM_W'(avg_x_r) * SUM_W'(WINDOW_DEPTH));
  assign rem_y  = sum_y_r - SUM_W'(SUM_W'(avg_y_r) * SUM_W'(WINDOW_DEPTH));

  assign dx      = (rd_x >= avg_x_r) ? rd_x - avg_x_r : avg_x_r - rd_x;
  assign dy      = (rd_y >= avg_y_r) ? rd_y - avg_y_r : avg_y_r - rd_y;
  assign dist_sq = {1'b0, sqx_r} + {1'b0, sqy_r};

  // At fixation onset the blend starts from the window average.
  assign base_x = (fix_r && !was_fix_r) ? avg_x_r : held_x_r;
  assign base_y = (fix_r && !was_fix_r) ? avg_y_r : held_y_r;
  assign wcomp  = 17'h10000 - {1'b0, weight};
  assign acc_x  = {1'b0, px_r} + (SQ_W+1)'(item_r.x) * (SQ_W+1)'(wcomp)
                + (SQ_W+1)'(32768);
  assign acc_y  = {1'b0, py_r} + (SQ_W+1)'(item_r.y) * (SQ_W+1)'(wcomp)
                + (SQ_W+1)'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      slot_r      <= '0;
      vbits_r     <= '0;
      rd_pend_r   <= 1'b0;
      sq_v_r      <= 1'b0;
      fix_r       <= 1'b0;
      was_fix_r   <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= iss;
      sq_v_r    <= rd_pend_r && (state_r == ST_DISP);
      if (state_r == ST_WRITE || state_r == ST_DIV_FIX) begin
        cnt_r <= '0;
      end else if (iss) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_WRITE) begin
        vbits_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      end
      if (state_r == ST_DIV_FIX) begin
        fix_r <= 1'b1;
      end else if (sq_v_r && (dist_sq > {1'b0, lim_r})) begin
        fix_r <= 1'b0;
      end
      if (state_r == ST_BLEND2) begin
        was_fix_r <= fix_r;
        if (fix_r) begin
          held_x_r <= acc_x[SQ_W-1:COORD_W];
          held_y_r <= acc_y[SQ_W-1:COORD_W];
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    rd_ok_r <= iss && vbits_r[raddr];
    if (state_r == ST_WRITE) begin
      lim_r   <= SQ_W'(threshold) * SQ_W'(threshold);
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (rd_pend_r && state_r == ST_SUM) begin
      sum_x_r <= sum_x_r + SUM_W'(rd_x);
      sum_y_r <= sum_y_r + SUM_W'(rd_y);
    end
    if (state_r == ST_DIV_MUL) begin
      avg_x_r <= prod_x[SUM_W+COORD_W-1:SUM_W];
      avg_y_r <= prod_y[SUM_W+COORD_W-1:SUM_W];
    end else if (state_r == ST_DIV_FIX) begin
      if (rem_x >= SUM_W'(WINDOW_DEPTH)) begin
        avg_x_r <= avg_x_r + 1'b1;
      end
      if (rem_y >= SUM_W'(WINDOW_DEPTH)) begin
        avg_y_r <= avg_y_r + 1'b1;
      end
    end
    sqx_r <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r <= SQ_W'(dy) * SQ_W'(dy);
    if (state_r == ST_BLEND1) begin
      px_r <= SQ_W'(base_x) * SQ_W'(weight);
      py_r <= SQ_W'(base_y) * SQ_W'(weight);
    end
    if (load_out) begin
      out_x_r   <= held_x_r;
      out_y_r   <= held_y_r;
      out_fix_r <= was_fix_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_smooth_x = out_x_r;
  assign out_smooth_y = out_y_r;
  assign out_fix      = out_fix_r;

endmodule

`default_nettype wire

@@ hdl/gaze_fixation_smoother.sv @@
// Top level of the gaze fixation smoother: configuration registers, front and back.
// Depends on gfs_pkg, gfs_front, gfs_back and gfs_ram.
//
//   channel | direction | payload
//   in_     | slave     | tdata {raw_y, raw_x}, tuser sample_valid
//   out_    | master    | tdata {smooth_y, smooth_x}, tuser in_fixation
//   cfg_    | write     | index 0 smoothing_weight, 1 dispersion_threshold
//
// A valid sample holds the back end from leaving the queue to loading its result,
// through the window write, the summing pass, the divide, the dispersion pass and
// the blend; the two passes over the window make one RAM read per cycle.
// An invalid sample goes from idle straight to the output state and repeats the held result.
// Reset is synchronous and clears the window valid bits at once; no clearing pass.
// A two-entry queue keeps accepting samples while a result waits on out_tready.
`default_nettype none

module gaze_fixation_smoother #(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [2*gfs_pkg::COORD_W-1:0]     in_tdata,   // raw_x, raw_y
  input  wire logic                              in_tuser,   // sample_valid
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [2*gfs_pkg::COORD_W-1:0]          out_tdata,  // smooth_x, smooth_y
  output logic                                   out_tuser,  // in_fixation
  input  wire logic                              cfg_we,
  input  wire logic [gfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gfs_pkg::CFG_W-1:0]         cfg_wdata
);

  import gfs_pkg::*;

  logic [CFG_W-1:0]   weight_r;
  logic [CFG_W-1:0]   thresh_r;
  logic               q_valid, q_pop;
  qitem_t             q_item;
  logic [COORD_W-1:0] smooth_x, smooth_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTH_WEIGHT:  weight_r <= cfg_wdata;
        REG_DISP_THRESHOLD: thresh_r <= cfg_wdata;
        default: begin
          weight_r <= weight_r;
        end
      endcase
    end
  end

  gfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  gfs_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .weight       (weight_r),
    .threshold    (thresh_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_smooth_x (smooth_x),
    .out_smooth_y (smooth_y),
    .out_fix      (out_tuser)
  );

  assign out_tdata = {smooth_y, smooth_x};

endmodule

`default_nettype wire

@@ hdl/gfs_checker.sv @@
// Port-level checks of the gaze fixation smoother, bound to its top level.
// Depends on gfs_pkg and gaze_fixation_smoother_assert.svh.
`default_nettype none
`include "gaze_fixation_smoother_assert.svh"

module gfs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [2*gfs_pkg::COORD_W-1:0] out_tdata,
  input wire logic                          out_tuser
);

  // A stalled result must hold still until it is taken.
  `GFS_ASSERT_RUN(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Reset empties the result register.
  `GFS_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_tvalid, "result pending after reset")

  // Reset empties the sample queue, so the block can take a sample at once.
  `GFS_ASSERT_ALWAYS(a_rst_in, clk, !rst_n |=> in_tready, "not ready after reset")

endmodule

bind gaze_fixation_smoother gfs_checker u_gfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ test/gaze_fixation_smoother_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the gaze fixation smoother: watches the sample, result and register ports,
// predicts each smoothed point and compares it with what the block returns.
// Depends on gfs_pkg for the field widths and register indexes.

module gaze_fixation_smoother_checker #(
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [2*gfs_pkg::COORD_W-1:0]     in_tdata,   // raw_x, raw_y
  input  logic                              in_tuser,   // sample_valid
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [2*gfs_pkg::COORD_W-1:0]     out_tdata,  // smooth_x, smooth_y
  input  logic                              out_tuser,  // in_fixation
  input  logic                              cfg_we,
  input  logic [gfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfs_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                mismatch_count,
  output int                                results_owed
);

  localparam int CW = gfs_pkg::COORD_W;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   fixating;
  } gaze_point_t;

  logic [gfs_pkg::CFG_W-1:0] blend_weight;
  logic [gfs_pkg::CFG_W-1:0] radius;
  coord_t                    ring_x [DEPTH];
  coord_t                    ring_y [DEPTH];
  int unsigned               ring_slot;
  coord_t                    held_x;
  coord_t                    held_y;
  logic                      fixating;
  gaze_point_t               expected_points [$];
  int                        fails = 0;

  // Rounds half up; the weight applies to the old point.
  function automatic coord_t blend_toward(coord_t old_pt, coord_t fresh);
    logic [63:0] acc;
    acc = 64'(old_pt) * 64'(blend_weight)
        + 64'(fresh) * (64'd65536 - 64'(blend_weight)) + 64'd32768;
    return acc[CW+15:16];
  endfunction

  function automatic gaze_point_t predict_smoothed_gaze(logic valid, coord_t rx, coord_t ry);
    logic [63:0] sum_x, sum_y, avg_x, avg_y, dx, dy, limit;
    logic        fix;
    int          i;
    gaze_point_t res;
    if (valid) begin
      ring_x[ring_slot] = rx;
      ring_y[ring_slot] = ry;
      sum_x = '0;
      sum_y = '0;
      for (i = 0; i < DEPTH; i++) begin
        sum_x += 64'(ring_x[i]);
        sum_y += 64'(ring_y[i]);
      end
      avg_x = sum_x / DEPTH;
      avg_y = sum_y / DEPTH;
      limit = 64'(radius) * 64'(radius);
      fix = 1'b1;
      for (i = 0; i < DEPTH; i++) begin
        dx = (64'(ring_x[i]) > avg_x) ? 64'(ring_x[i]) - avg_x : avg_x - 64'(ring_x[i]);
        dy = (64'(ring_y[i]) > avg_y) ? 64'(ring_y[i]) - avg_y : avg_y - 64'(ring_y[i]);
        if (dx * dx + dy * dy > limit) fix = 1'b0;
      end
      ring_slot = (ring_slot + 1) % DEPTH;
      // At onset the held point first jumps to the window average, then blends.
      if (fix && !fixating) begin
        held_x = avg_x[CW-1:0];
        held_y = avg_y[CW-1:0];
      end
      if (fix) begin
        held_x = blend_toward(held_x, rx);
        held_y = blend_toward(held_y, ry);
      end
      fixating = fix;
    end
    res.x        = held_x;
    res.y        = held_y;
    res.fixating = fixating;
    return res;
  endfunction

  always @(posedge clk) begin
    gaze_point_t want;
    int          i;
    if (!rst_n) begin
      blend_weight = gfs_pkg::WEIGHT_RESET;
      radius       = gfs_pkg::THRESH_RESET;
      for (i = 0; i < DEPTH; i++) begin
        ring_x[i] = '0;
        ring_y[i] = '0;
      end
      ring_slot = 0;
      held_x    = '0;
      held_y    = '0;
      fixating  = 1'b0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == gfs_pkg::REG_SMOOTH_WEIGHT) blend_weight = cfg_wdata;
        else if (cfg_index == gfs_pkg::REG_DISP_THRESHOLD) radius = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        expected_points.push_back(predict_smoothed_gaze(in_tuser, in_tdata[CW-1:0],
                                                        in_tdata[2*CW-1:CW]));
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("result transaction with no sample waiting for it");
          fails++;
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[CW-1:0] !== want.x) begin
            $error("smooth_x: expected %0d, actual %0d", want.x, out_tdata[CW-1:0]);
            fails++;
          end
          if (out_tdata[2*CW-1:CW] !== want.y) begin
            $error("smooth_y: expected %0d, actual %0d", want.y, out_tdata[2*CW-1:CW]);
            fails++;
          end
          if (out_tuser !== want.fixating) begin
            $error("in_fixation: expected %0d, actual %0d", want.fixating, out_tuser);
            fails++;
          end
        end
      end
    end
    mismatch_count <= fails;
    results_owed   <= expected_points.size();
  end

endmodule

@@ test/gaze_fixation_smoother_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the gaze fixation smoother: clock, reset, sample and register stimulus.
// Depends on gfs_pkg, the block itself and gaze_fixation_smoother_checker.

module gaze_fixation_smoother_test;

  import gfs_pkg::*;

  localparam int WINDOW_DEPTH = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES       = 4;
  localparam int PHASE_VALID  = 250;

  typedef logic [COORD_W-1:0] coord_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [2*COORD_W-1:0]   in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*COORD_W-1:0]   out_tdata;
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = REG_SMOOTH_WEIGHT;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  int                     mismatch_count;
  int                     results_owed;
  bit                     send_idle = 1'b0;
  bit                     recv_idle = 1'b0;
  int                     stall_left = 0;
  int                     quiet_cycles = 0;
  int                     valid_sent = 0;
  logic [CFG_W-1:0]       threshold_now = THRESH_RESET;

  gaze_fixation_smoother #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  gaze_fixation_smoother_checker #(
    .DEPTH(WINDOW_DEPTH)
  ) gaze_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #5 clk = ~clk;

  // Result side: while recv_idle is set, out_tready drops at random for bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Leaves tvalid high after the transaction so back-to-back samples need no toggle.
  task automatic send_sample(input logic valid, input coord_t x, input coord_t y);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= valid;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (valid) valid_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic program_settings(input logic [CFG_W-1:0] weight,
                                  input logic [CFG_W-1:0] threshold);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SMOOTH_WEIGHT;
    cfg_wdata <= weight;
    @(posedge clk);
    cfg_index <= REG_DISP_THRESHOLD;
    cfg_wdata <= threshold;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_now = threshold;
    @(posedge clk);
  endtask

  // A run of samples scattered around one point, sized to the current threshold,
  // with an occasional dropped sample mixed in.
  task automatic send_fixation_cluster();
    int cx, cy, span, px, py, len;
    cx   = $urandom_range(0, 65535);
    cy   = $urandom_range(0, 65535);
    span = (threshold_now == 0) ? 0 : int'(threshold_now) / int'($urandom_range(1, 4));
    len  = $urandom_range(4, 20);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) begin
        send_sample(1'b0, coord_t'($urandom), coord_t'($urandom));
      end else begin
        px = cx - span + int'($urandom_range(0, 2 * span));
        py = cy - span + int'($urandom_range(0, 2 * span));
        px = (px < 0) ? 0 : (px > 65535) ? 65535 : px;
        py = (py < 0) ? 0 : (py > 65535) ? 65535 : py;
        send_sample(1'b1, coord_t'(px), coord_t'(py));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] weight, threshold;
    int               phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the zero-filled window makes a sample at the origin a fixation onset.
    send_sample(1'b1, 16'd0, 16'd0);
    send_sample(1'b0, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'd16, 16'd16);
    send_sample(1'b1, 16'hFFFF, 16'd0);
    send_sample(1'b1, 16'd0, 16'hFFFF);
    send_sample(1'b0, 16'hAAAA, 16'h5555);
    wait_for_results();

    // Zero threshold: only a window of identical points fixates.
    program_settings(16'd0, 16'd0);
    repeat (WINDOW_DEPTH) send_sample(1'b1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'hFFFE, 16'hFFFF);
    wait_for_results();

    program_settings(16'hFFFF, 16'hFFFF);
    repeat (4) send_sample(1'b1, 16'd0, 16'd0);
    repeat (4) send_sample(1'b1, 16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'h5555, 16'hAAAA);
    send_sample(1'b0, 16'd0, 16'd0);
    wait_for_results();

    for (phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       weight = '0;
        1:       weight = '1;
        default: weight = CFG_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       threshold = '0;
        1:       threshold = '1;
        default: threshold = CFG_W'($urandom_range(16, 2000));
      endcase
      program_settings(weight, threshold);
      valid_sent = 0;
      while (valid_sent < PHASE_VALID) begin
        if (phase < PHASES - 1) begin
          send_idle = $urandom_range(0, 2) != 0;
          recv_idle <= $urandom_range(0, 2) != 0;
        end else begin
          send_idle = 1'b0;
          recv_idle <= 1'b0;
        end
        if ($urandom_range(0, 9) < 7)
          send_fixation_cluster();
        else
          repeat ($urandom_range(1, 4))
            send_sample(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom));
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
